[rtl/core/bba_pkg.sv]
// bba_pkg: shared sizes, codes and helpers of the buddy block allocator
// no dependencies; used by buddy_block_allocator_unit and bba_checker under rtl/core
package bba_pkg;

	localparam int POOL_ORDER        = 20;
	localparam int SPLIT_FLOOR_ORDER = 6;
	localparam int LEAF_ORDER        = SPLIT_FLOOR_ORDER + 1;
	localparam int LEVELS            = POOL_ORDER - LEAF_ORDER;
	localparam int LEAVES            = 1 << LEVELS;
	localparam int MASK_W            = LEVELS + 1;
	localparam int NODE_W            = LEVELS + 1;
	localparam int LVL_W             = $clog2(LEVELS + 1);
	localparam int LEAF_W            = LEVELS;
	localparam int POOL_W            = POOL_ORDER;
	localparam int NEED_W            = 22;
	localparam int ORD_W             = 5;
	localparam int HDR_W             = 7;
	localparam int REQ_W             = 21;
	localparam int REL_W             = 20;
	localparam int STATUS_W          = 2;
	localparam int OFF_W             = 20;
	localparam int TAG_W             = ORD_W + 1;
	localparam int IN_DATA_W         = 48;
	localparam int OUT_DATA_W        = 32;

	localparam logic [HDR_W-1:0]  HDR_RESET  = 7'd24;
	localparam logic [NEED_W-1:0] POOL_BYTES = NEED_W'(1) << POOL_ORDER;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_BADSIZE = 2'd1,
		ST_NOMEM   = 2'd2,
		ST_BADFREE = 2'd3
	} status_t;

	typedef enum logic {
		FN_ALLOC = 1'b0,
		FN_FREE  = 1'b1
	} func_t;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_DECODE,
		S_TAG,
		S_DN_RD,
		S_DN_WT,
		S_UP_RD,
		S_UP_WR,
		S_DONE
	} state_t;

	// ceiling log2 of a nonzero value
	function automatic logic [5:0] ceil_log2(input logic [NEED_W-1:0] x);
		logic [NEED_W-1:0] y;
		logic [5:0]        r;
		y = x - NEED_W'(1);
		r = '0;
		for (int i = 0; i < NEED_W; i++) begin
			if (y[i]) r = 6'(i + 1);
		end
		return r;
	endfunction

endpackage

[rtl/core/bba_ram.sv]
// bba_ram: generic single-port synchronous ram, registered read
// no dependencies
module bba_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[addr] <= wdata;
		rdata <= mem[addr];
	end

endmodule

[rtl/core/buddy_block_allocator_unit.sv]
// buddy_block_allocator_unit: binary buddy allocator over one pool
// depends on bba_pkg and bba_ram
//
// usage
//  - input stream s_axis: tuser carries the operation (0 allocate, 1 free),
//    tdata the request size and the offset to release; one transfer is one request
//  - output stream m_axis: one transfer per request with status, user data
//    offset and block order
//  - cfg_we / cfg_wdata write the header size; write only while idle
//  - state lives in two rams: per tree node pair, a mask of which block orders
//    are free somewhere below; per leaf, the allocated flag and block order
//  - allocate: up to LEVELS pair reads walking down, then one read-modify-write
//    per level back to the root; free: one tag read, then the same upward
//    walk, merging buddies on the way
//  - one request in flight: s_axis_tready is high only while idle, so the next
//    request is taken once the result of the last one has gone to the output register
//  - after reset a clearing pass over all 2^LEVELS (8192) addresses zeroes both rams;
//    s_axis_tready stays low meanwhile, configuration writes are still taken
//  - results sit in an output register; a stalled receiver holds the block in
//    its final state until the waiting result is taken
module buddy_block_allocator_unit (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// tdata: request_bytes[20:0], release_offset[40:21], zero fill
	input  logic [bba_pkg::IN_DATA_W-1:0]        s_axis_tdata,
	// tuser: func
	input  logic                                 s_axis_tuser,
	input  logic                                 s_axis_tvalid,
	output logic                                 s_axis_tready,
	// tdata: status[1:0], data_offset[21:2], block_order[26:22], zero fill
	output logic [bba_pkg::OUT_DATA_W-1:0]       m_axis_tdata,
	output logic                                 m_axis_tvalid,
	input  logic                                 m_axis_tready,
	input  logic                                 cfg_we,
	input  logic [bba_pkg::HDR_W-1:0]            cfg_wdata
);

	// registers
	bba_pkg::state_t state_q, state_d;
	logic [bba_pkg::HDR_W-1:0]    hdr_q;
	logic [bba_pkg::MASK_W-1:0]   root_q;       // free-order mask of the whole pool
	logic [bba_pkg::LEAF_W-1:0]   clr_q;
	logic                         func_q;
	logic [bba_pkg::REQ_W-1:0]    req_q;
	logic [bba_pkg::REL_W-1:0]    rel_q;
	logic [bba_pkg::POOL_W-1:0]   start_q;
	logic [bba_pkg::LEAF_W-1:0]   leaf_q;
	logic [bba_pkg::ORD_W-1:0]    ord_q;
	logic [bba_pkg::LVL_W-1:0]    oidx_q;       // mask bit of the block order found
	logic [bba_pkg::LVL_W-1:0]    dfound_q;     // depth of the free block found
	logic [bba_pkg::LVL_W-1:0]    tgt_q;        // depth of the granted block
	logic [bba_pkg::LVL_W-1:0]    d_q;
	logic [bba_pkg::NODE_W-1:0]   n_q;
	logic [bba_pkg::NODE_W-1:0]   blk_q;
	logic [bba_pkg::MASK_W-1:0]   cur_q;        // mask of node n_q after update
	logic                         merge_q;
	bba_pkg::status_t             status_q;
	logic                         out_valid_q;
	logic [bba_pkg::OUT_DATA_W-1:0] out_data_q;

	// ram ports
	logic                             pair_we;
	logic [bba_pkg::LEAF_W-1:0]       pair_addr;
	logic [2*bba_pkg::MASK_W-1:0]     pair_wdata, pair_rdata;
	logic                             tag_we;
	logic [bba_pkg::LEAF_W-1:0]       tag_addr;
	logic [bba_pkg::TAG_W-1:0]        tag_wdata, tag_rdata;

	bba_ram #(.WIDTH(2*bba_pkg::MASK_W), .DEPTH(bba_pkg::LEAVES)) u_pair_ram (
		.clk(clk), .we(pair_we), .addr(pair_addr), .wdata(pair_wdata), .rdata(pair_rdata)
	);

	bba_ram #(.WIDTH(bba_pkg::TAG_W), .DEPTH(bba_pkg::LEAVES)) u_tag_ram (
		.clk(clk), .we(tag_we), .addr(tag_addr), .wdata(tag_wdata), .rdata(tag_rdata)
	);

	// allocate decode
	logic [bba_pkg::NEED_W-1:0] need;
	logic [5:0]                 ord_raw, ord_cl;
	logic                       size_bad, too_big, found;
	logic [bba_pkg::LVL_W-1:0]  idx_need, o_idx;
	logic [bba_pkg::MASK_W-1:0] cand;

	always_comb begin
		need     = bba_pkg::NEED_W'(req_q) + bba_pkg::NEED_W'(hdr_q);
		ord_raw  = bba_pkg::ceil_log2(need);
		ord_cl   = (ord_raw < 6'(bba_pkg::LEAF_ORDER)) ? 6'(bba_pkg::LEAF_ORDER) : ord_raw;
		size_bad = (req_q == '0) || (bba_pkg::NEED_W'(req_q) > bba_pkg::POOL_BYTES);
		too_big  = ord_cl > 6'(bba_pkg::POOL_ORDER);
		idx_need = bba_pkg::LVL_W'(ord_cl - 6'(bba_pkg::LEAF_ORDER));
		cand     = root_q & ~((bba_pkg::MASK_W'(1) << idx_need) - bba_pkg::MASK_W'(1));
		found    = |cand;
		o_idx    = '0;
		// lowest sufficient order wins
		for (int i = bba_pkg::MASK_W - 1; i >= 0; i--) begin
			if (cand[i]) o_idx = bba_pkg::LVL_W'(i);
		end
	end

	// free decode
	logic                         rel_lt;
	logic [bba_pkg::POOL_W-1:0]   start_c;
	logic                         misalign;
	logic                         t_bad;
	logic [bba_pkg::ORD_W-1:0]    t_ord;
	logic [bba_pkg::LVL_W-1:0]    t_d;
	logic [bba_pkg::NODE_W-1:0]   t_n;

	always_comb begin
		rel_lt   = rel_q < bba_pkg::REL_W'(hdr_q);
		start_c  = bba_pkg::POOL_W'(rel_q - bba_pkg::REL_W'(hdr_q));
		misalign = |start_c[bba_pkg::LEAF_ORDER-1:0];
		t_ord    = tag_rdata[bba_pkg::ORD_W-1:0];
		t_bad    = !tag_rdata[bba_pkg::ORD_W] || (t_ord < bba_pkg::ORD_W'(bba_pkg::LEAF_ORDER))
		           || (t_ord > bba_pkg::ORD_W'(bba_pkg::POOL_ORDER));
		t_d      = bba_pkg::LVL_W'(bba_pkg::ORD_W'(bba_pkg::POOL_ORDER) - t_ord);
		t_n      = (bba_pkg::NODE_W'(1) << t_d) + bba_pkg::NODE_W'(start_q >> t_ord);
	end

	// walk down: follow the child that holds the wanted order
	logic [bba_pkg::MASK_W-1:0] left_m, right_m;
	logic                       go_right;
	logic [bba_pkg::NODE_W-1:0] dn_n;
	logic [bba_pkg::LVL_W-1:0]  dn_d;

	assign left_m   = pair_rdata[bba_pkg::MASK_W-1:0];
	assign right_m  = pair_rdata[2*bba_pkg::MASK_W-1:bba_pkg::MASK_W];
	assign go_right = !left_m[oidx_q];
	assign dn_n     = {n_q[bba_pkg::NODE_W-2:0], go_right};
	assign dn_d     = d_q + bba_pkg::LVL_W'(1);

	// walk up: rewrite the parent pair, merge buddies on a free
	logic [bba_pkg::LVL_W-1:0]  own_idx;
	logic [bba_pkg::MASK_W-1:0] sib, sib_new, cur_next;
	logic                       merge_ok, split_here;
	logic [bba_pkg::NODE_W-1:0] parent;

	always_comb begin
		own_idx    = bba_pkg::LVL_W'(bba_pkg::LEVELS) - d_q;
		sib        = n_q[0] ? left_m : right_m;
		merge_ok   = merge_q && sib[own_idx];
		split_here = d_q > dfound_q;  // parent was split, upper half is now free
		sib_new    = split_here ? (bba_pkg::MASK_W'(1) << own_idx) : sib;
		parent     = n_q >> 1;
		if (merge_ok) begin
			pair_wdata = '0;
			cur_next   = bba_pkg::MASK_W'(1) << (own_idx + bba_pkg::LVL_W'(1));
		end else begin
			pair_wdata = n_q[0] ? {cur_q, sib_new} : {sib_new, cur_q};
			cur_next   = cur_q | sib_new;
		end
		if (state_q == bba_pkg::S_CLEAR) pair_wdata = '0;
	end

	// result of an allocate
	logic [bba_pkg::POOL_W-1:0] blk_start;
	logic [bba_pkg::OFF_W-1:0]  res_off;

	always_comb begin
		blk_start = bba_pkg::POOL_W'(blk_q ^ (bba_pkg::NODE_W'(1) << tgt_q)) << ord_q;
		res_off   = (func_q == bba_pkg::FN_FREE) ? rel_q
		            : bba_pkg::OFF_W'(blk_start + bba_pkg::POOL_W'(hdr_q));
	end

	logic out_free;
	assign out_free      = !out_valid_q || m_axis_tready;
	assign s_axis_tready = (state_q == bba_pkg::S_IDLE);
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	// next state and ram controls
	always_comb begin
		state_d   = state_q;
		pair_we   = 1'b0;
		pair_addr = parent[bba_pkg::LEAF_W-1:0];
		tag_we    = 1'b0;
		tag_addr  = leaf_q;
		tag_wdata = '0;
		unique case (state_q)
			bba_pkg::S_CLEAR: begin
				pair_we   = 1'b1;
				pair_addr = clr_q;
				tag_we    = 1'b1;
				tag_addr  = clr_q;
				if (&clr_q) state_d = bba_pkg::S_IDLE;
			end
			bba_pkg::S_IDLE: begin
				if (s_axis_tvalid) state_d = bba_pkg::S_DECODE;
			end
			bba_pkg::S_DECODE: begin
				tag_addr = start_c[bba_pkg::POOL_W-1:bba_pkg::LEAF_ORDER];
				if (func_q == bba_pkg::FN_ALLOC) begin
					if (size_bad || too_big || !found) state_d = bba_pkg::S_DONE;
					else if (o_idx != bba_pkg::LVL_W'(bba_pkg::LEVELS)) state_d = bba_pkg::S_DN_RD;
					else if (idx_need == bba_pkg::LVL_W'(bba_pkg::LEVELS))
						state_d = bba_pkg::S_DONE;
					else state_d = bba_pkg::S_UP_RD;
				end else begin
					if (rel_lt || misalign) state_d = bba_pkg::S_DONE;
					else state_d = bba_pkg::S_TAG;
				end
			end
			bba_pkg::S_TAG: begin
				if (!t_bad) tag_we = 1'b1;
				if (t_bad || t_d == '0) state_d = bba_pkg::S_DONE;
				else state_d = bba_pkg::S_UP_RD;
			end
			bba_pkg::S_DN_RD: begin
				pair_addr = n_q[bba_pkg::LEAF_W-1:0];
				state_d   = bba_pkg::S_DN_WT;
			end
			bba_pkg::S_DN_WT: begin
				if (dn_d < dfound_q) state_d = bba_pkg::S_DN_RD;
				else state_d = bba_pkg::S_UP_RD;
			end
			bba_pkg::S_UP_RD: begin
				state_d = bba_pkg::S_UP_WR;
			end
			bba_pkg::S_UP_WR: begin
				pair_we = 1'b1;
				if (parent == bba_pkg::NODE_W'(1)) state_d = bba_pkg::S_DONE;
				else state_d = bba_pkg::S_UP_RD;
			end
			bba_pkg::S_DONE: begin
				// stamp the granted block at its first leaf
				if (func_q == bba_pkg::FN_ALLOC && status_q == bba_pkg::ST_OK) begin
					tag_we    = 1'b1;
					tag_addr  = blk_start[bba_pkg::POOL_W-1:bba_pkg::LEAF_ORDER];
					tag_wdata = {1'b1, ord_q};
				end
				if (out_free) state_d = bba_pkg::S_IDLE;
			end
			default: state_d = bba_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= bba_pkg::S_CLEAR;
			clr_q       <= '0;
			hdr_q       <= bba_pkg::HDR_RESET;
			root_q      <= bba_pkg::MASK_W'(1) << bba_pkg::LEVELS;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) hdr_q <= cfg_wdata;
			if (state_q == bba_pkg::S_CLEAR) clr_q <= clr_q + bba_pkg::LEAF_W'(1);
			if (state_q == bba_pkg::S_DONE && out_free) out_valid_q <= 1'b1;
			else if (m_axis_tready) out_valid_q <= 1'b0;
			case (state_q)
				bba_pkg::S_DECODE: begin
					if (func_q == bba_pkg::FN_ALLOC && !size_bad && !too_big && found &&
					    o_idx == bba_pkg::LVL_W'(bba_pkg::LEVELS) &&
					    idx_need == bba_pkg::LVL_W'(bba_pkg::LEVELS))
						root_q <= '0;
				end
				bba_pkg::S_TAG: begin
					if (!t_bad && t_d == '0) root_q <= bba_pkg::MASK_W'(1) << bba_pkg::LEVELS;
				end
				bba_pkg::S_UP_WR: begin
					if (parent == bba_pkg::NODE_W'(1)) root_q <= cur_next;
				end
				default: ;
			endcase
		end
	end

	// payload and walk registers
	always_ff @(posedge clk) begin
		case (state_q)
			bba_pkg::S_IDLE: begin
				func_q <= s_axis_tuser;
				req_q  <= s_axis_tdata[bba_pkg::REQ_W-1:0];
				rel_q  <= s_axis_tdata[bba_pkg::REQ_W+bba_pkg::REL_W-1:bba_pkg::REQ_W];
			end
			bba_pkg::S_DECODE: begin
				start_q <= start_c;
				leaf_q  <= start_c[bba_pkg::POOL_W-1:bba_pkg::LEAF_ORDER];
				ord_q   <= bba_pkg::ORD_W'(ord_cl);
				oidx_q  <= o_idx;
				cur_q   <= '0;
				merge_q <= 1'b0;
				blk_q   <= bba_pkg::NODE_W'(1) << (bba_pkg::LVL_W'(bba_pkg::LEVELS) - idx_need);
				dfound_q <= bba_pkg::LVL_W'(bba_pkg::LEVELS) - o_idx;
				tgt_q   <= bba_pkg::LVL_W'(bba_pkg::LEVELS) - idx_need;
				// walk down from the root, or split the whole pool straight up
				n_q     <= (o_idx != bba_pkg::LVL_W'(bba_pkg::LEVELS)) ? bba_pkg::NODE_W'(1)
				           : bba_pkg::NODE_W'(1) << (bba_pkg::LVL_W'(bba_pkg::LEVELS) - idx_need);
				d_q     <= (o_idx != bba_pkg::LVL_W'(bba_pkg::LEVELS)) ? '0
				           : bba_pkg::LVL_W'(bba_pkg::LEVELS) - idx_need;
				if (func_q == bba_pkg::FN_ALLOC) begin
					if (size_bad) status_q <= bba_pkg::ST_BADSIZE;
					else if (too_big || !found) status_q <= bba_pkg::ST_NOMEM;
					else status_q <= bba_pkg::ST_OK;
				end else begin
					status_q <= (rel_lt || misalign) ? bba_pkg::ST_BADFREE : bba_pkg::ST_OK;
				end
			end
			bba_pkg::S_TAG: begin
				status_q <= t_bad ? bba_pkg::ST_BADFREE : bba_pkg::ST_OK;
				ord_q    <= t_ord;
				n_q      <= t_n;
				d_q      <= t_d;
				cur_q    <= bba_pkg::MASK_W'(1) << (bba_pkg::LVL_W'(bba_pkg::LEVELS) - t_d);
				merge_q  <= 1'b1;
				dfound_q <= bba_pkg::LVL_W'(bba_pkg::LEVELS);
			end
			bba_pkg::S_DN_WT: begin
				if (dn_d < dfound_q) begin
					n_q <= dn_n;
					d_q <= dn_d;
				end else begin
					// below the found block every level keeps its lower half
					n_q   <= dn_n << (tgt_q - dfound_q);
					blk_q <= dn_n << (tgt_q - dfound_q);
					d_q   <= tgt_q;
				end
			end
			bba_pkg::S_UP_WR: begin
				cur_q   <= cur_next;
				merge_q <= merge_ok;
				n_q     <= parent;
				d_q     <= d_q - bba_pkg::LVL_W'(1);
			end
			bba_pkg::S_DONE: begin
				if (out_free) begin
					if (status_q == bba_pkg::ST_OK)
						out_data_q <= bba_pkg::OUT_DATA_W'({ord_q, res_off, status_q});
					else
						out_data_q <= bba_pkg::OUT_DATA_W'(status_q);
				end
			end
			default: ;
		endcase
	end

endmodule

[rtl/core/bba_checker.sv]
// bba_checker: port-level assertions for the buddy block allocator
// depends on bba_pkg; bound to buddy_block_allocator_unit
module bba_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              s_axis_tvalid,
	input logic                              s_axis_tready,
	input logic [bba_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
	input logic                              m_axis_tvalid,
	input logic                              m_axis_tready
);

	logic [1:0]                 st;
	logic [bba_pkg::ORD_W-1:0]  ord;
	assign st  = m_axis_tdata[1:0];
	assign ord = m_axis_tdata[bba_pkg::OFF_W+bba_pkg::ORD_W+1:bba_pkg::OFF_W+2];

	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed while stalled");

	// one request at a time
	a_one: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("request taken while busy");

	// failed requests carry no offset or order
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && st != bba_pkg::ST_OK |-> m_axis_tdata[bba_pkg::OUT_DATA_W-1:2] == '0)
		else $error("error result with payload");

	// granted or released blocks lie between leaf and pool size
	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && st == bba_pkg::ST_OK |->
		ord >= bba_pkg::ORD_W'(bba_pkg::LEAF_ORDER) && ord <= bba_pkg::ORD_W'(bba_pkg::POOL_ORDER))
		else $error("block order out of range");

endmodule

bind buddy_block_allocator_unit bba_checker u_bba_checker (
	.clk(clk), .arst_n(arst_n), .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
	.m_axis_tdata(m_axis_tdata), .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready)
);

[bench/buddy_block_allocator_unit_tb.sv]
// buddy_block_allocator_unit_tb: self-checking bench for the buddy block allocator
// depends on bba_pkg and the buddy_block_allocator_unit rtl; drives streams, predicts results
module buddy_block_allocator_unit_tb;

	localparam int NODE_CNT   = 2 << bba_pkg::LEVELS;
	localparam int CYCLE_CAP  = 900000;
	localparam int DRAIN_WAIT = 4 * bba_pkg::LEVELS + 20;
	localparam int HOLD_LEN   = 300;

	typedef struct packed {
		bba_pkg::status_t          status;
		logic [bba_pkg::OFF_W-1:0] data_offset;
		logic [bba_pkg::ORD_W-1:0] block_order;
	} grant_t;

	typedef struct {
		bba_pkg::func_t            func;
		logic [bba_pkg::REQ_W-1:0] req;
		logic [bba_pkg::REL_W-1:0] rel;
		logic                      typed;
		grant_t                    want;
	} row_t;

	logic                           clk = 1'b0;
	logic                           arst_n = 1'b0;
	logic [bba_pkg::IN_DATA_W-1:0]  s_axis_tdata = '0;
	logic                           s_axis_tuser = 1'b0;
	logic                           s_axis_tvalid = 1'b0;
	logic                           s_axis_tready;
	logic [bba_pkg::OUT_DATA_W-1:0] m_axis_tdata;
	logic                           m_axis_tvalid;
	logic                           m_axis_tready = 1'b0;
	logic                           cfg_we = 1'b0;
	logic [bba_pkg::HDR_W-1:0]      cfg_wdata = '0;

	buddy_block_allocator_unit uut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	always #5 clk = ~clk;

	// shadow allocator state
	bit                        node_free [NODE_CNT];
	logic [bba_pkg::ORD_W-1:0] leaf_ord [bba_pkg::LEAVES];
	bit                        leaf_busy [bba_pkg::LEAVES];
	logic [bba_pkg::HDR_W-1:0] hdr;
	logic [bba_pkg::OFF_W-1:0] live_q [$];   // offsets granted and not yet released
	grant_t                    grant_q [$];  // results still owed by the block
	int               errors = 0;
	int               row_errors = 0;
	int               cycles = 0;
	int               send_idle = 0;  // percent of cycles the sender idles
	int               recv_idle = 0;  // percent of cycles the receiver stalls
	bit               hold_go = 1'b0; // starts the long receiver hold-off
	int               hold_cnt = 0;   // cycles of hold-off spent so far

	function automatic grant_t alloc_predict(logic [bba_pkg::REQ_W-1:0] req);
		grant_t g;
		longint need;
		int ord, o, n, d, lvl;
		bit hit;
		g = '{bba_pkg::ST_OK, '0, '0};
		if (req == 0 || req > (1 << bba_pkg::POOL_ORDER)) begin
			g.status = bba_pkg::ST_BADSIZE;
			return g;
		end
		need = longint'(req) + hdr;
		ord = 0;
		while ((longint'(1) << ord) < need) ord++;
		if (ord < bba_pkg::LEAF_ORDER) ord = bba_pkg::LEAF_ORDER;
		if (ord > bba_pkg::POOL_ORDER) begin
			g.status = bba_pkg::ST_NOMEM;
			return g;
		end
		hit = 0;
		n = 0;
		d = 0;
		for (o = ord; o <= bba_pkg::POOL_ORDER && !hit; o++) begin
			lvl = bba_pkg::POOL_ORDER - o;
			for (int i = 1 << lvl; i < (2 << lvl); i++) begin
				if (node_free[i]) begin
					n = i;
					d = lvl;
					hit = 1;
					break;
				end
			end
		end
		if (!hit) begin
			g.status = bba_pkg::ST_NOMEM;
			return g;
		end
		// split keeps the lower half, upper halves go free
		while (d < bba_pkg::POOL_ORDER - ord) begin
			node_free[n] = 0;
			n = 2 * n;
			node_free[n + 1] = 1;
			d++;
		end
		node_free[n] = 0;
		n = (n - (1 << d)) << ord;
		leaf_busy[n >> bba_pkg::LEAF_ORDER] = 1;
		leaf_ord[n >> bba_pkg::LEAF_ORDER] = bba_pkg::ORD_W'(ord);
		g.data_offset = bba_pkg::OFF_W'(n + hdr);
		g.block_order = bba_pkg::ORD_W'(ord);
		live_q.push_back(g.data_offset);
		return g;
	endfunction

	function automatic grant_t free_predict(logic [bba_pkg::REL_W-1:0] rel);
		grant_t g;
		int start, leaf, ord, n;
		g = '{bba_pkg::ST_BADFREE, '0, '0};
		if (rel < hdr) return g;
		start = int'(rel) - hdr;
		if (start[bba_pkg::LEAF_ORDER-1:0] != 0) return g;
		leaf = start >> bba_pkg::LEAF_ORDER;
		if (!leaf_busy[leaf]) return g;
		ord = leaf_ord[leaf];
		if (ord < bba_pkg::LEAF_ORDER || ord > bba_pkg::POOL_ORDER) return g;
		leaf_busy[leaf] = 0;
		leaf_ord[leaf] = '0;
		n = (1 << (bba_pkg::POOL_ORDER - ord)) + (start >> ord);
		node_free[n] = 1;
		// merge with the address-xor buddy while it is free
		while (n > 1 && node_free[n ^ 1]) begin
			node_free[n] = 0;
			node_free[n ^ 1] = 0;
			n >>= 1;
			node_free[n] = 1;
		end
		foreach (live_q[i]) if (live_q[i] == rel) begin
			live_q.delete(i);
			break;
		end
		g = '{bba_pkg::ST_OK, rel, bba_pkg::ORD_W'(ord)};
		return g;
	endfunction

	// one request transfer on the input stream, then tvalid is dropped again
	task automatic send_req(bba_pkg::func_t fn, logic [bba_pkg::REQ_W-1:0] req,
		logic [bba_pkg::REL_W-1:0] rel);
		while ($urandom_range(99) < send_idle) @(posedge clk);
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= fn;
		s_axis_tdata  <= {7'b0, rel, req};
		do @(posedge clk); while (!s_axis_tready);
		s_axis_tvalid <= 1'b0;
		grant_q.push_back(fn == bba_pkg::FN_ALLOC ? alloc_predict(req) : free_predict(rel));
		@(posedge clk);
	endtask

	// header write while idle; extra wait covers the block finishing its last step
	task automatic write_hdr(logic [bba_pkg::HDR_W-1:0] v);
		while (grant_q.size() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		hdr = v;
	endtask

	task automatic random_req();
		int pick;
		pick = $urandom_range(99);
		if (pick < 45) begin
			// mostly small sizes, a few large ones
			if ($urandom_range(9) == 0)
				send_req(bba_pkg::FN_ALLOC,
					bba_pkg::REQ_W'($urandom_range(1 << bba_pkg::POOL_ORDER, 1)),
					bba_pkg::REL_W'($urandom));
			else
				send_req(bba_pkg::FN_ALLOC, bba_pkg::REQ_W'($urandom_range(3000, 1)),
					bba_pkg::REL_W'($urandom));
		end else if (pick < 85 && live_q.size() != 0) begin
			send_req(bba_pkg::FN_FREE, bba_pkg::REQ_W'($urandom),
				live_q[$urandom_range(live_q.size() - 1)]);
		end else if (pick < 92) begin
			send_req(pick[0] ? bba_pkg::FN_ALLOC : bba_pkg::FN_FREE, bba_pkg::REQ_W'($urandom),
				bba_pkg::REL_W'($urandom));
		end else begin
			// near-miss free: misaligned or shifted off a live block
			send_req(bba_pkg::FN_FREE, bba_pkg::REQ_W'($urandom),
				(live_q.size() != 0 ? live_q[0] : bba_pkg::REL_W'(hdr))
				+ bba_pkg::REL_W'($urandom_range(200, 1)));
		end
	endtask

	// receiver: random stalls plus one long hold-off
	always @(posedge clk) begin
		if (hold_go && hold_cnt < HOLD_LEN) begin
			hold_cnt <= hold_cnt + 1;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= recv_idle);
		end
	end

	// result checker
	always @(posedge clk) begin
		grant_t got, exp_g;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = '{bba_pkg::status_t'(m_axis_tdata[1:0]), m_axis_tdata[21:2],
				m_axis_tdata[26:22]};
			if (grant_q.size() == 0) begin
				$error("unexpected result transfer %h", m_axis_tdata);
				errors++;
			end else begin
				exp_g = grant_q.pop_front();
				if (got.status != exp_g.status) begin
					$error("status expected %0d actual %0d", exp_g.status, got.status);
					errors++;
				end
				if (got.data_offset != exp_g.data_offset) begin
					$error("data_offset expected %0h actual %0h",
						exp_g.data_offset, got.data_offset);
					errors++;
				end
				if (got.block_order != exp_g.block_order) begin
					$error("block_order expected %0d actual %0d",
						exp_g.block_order, got.block_order);
					errors++;
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_CAP) begin
			$display("buddy_block_allocator_unit_tb failed");
			$finish;
		end
	end

	row_t dir_rows [$];

	task automatic add_row(bba_pkg::func_t fn, int req, int rel, bit typed,
		bba_pkg::status_t st, int off, int ord);
		row_t r;
		r.func = fn;
		r.req = bba_pkg::REQ_W'(req);
		r.rel = bba_pkg::REL_W'(rel);
		r.typed = typed;
		r.want = '{st, bba_pkg::OFF_W'(off), bba_pkg::ORD_W'(ord)};
		dir_rows.push_back(r);
	endtask

	initial begin
		grant_t pred;
		int done_items;
		foreach (node_free[i]) node_free[i] = 0;
		node_free[1] = 1;
		foreach (leaf_busy[i]) begin
			leaf_busy[i] = 0;
			leaf_ord[i] = '0;
		end
		hdr = bba_pkg::HDR_RESET;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// directed rows; typed results only where obvious from reset state
		add_row(bba_pkg::FN_ALLOC, 0, 0, 1, bba_pkg::ST_BADSIZE, 0, 0);
		add_row(bba_pkg::FN_ALLOC, (1 << bba_pkg::POOL_ORDER) + 1, 0, 1,
			bba_pkg::ST_BADSIZE, 0, 0);
		add_row(bba_pkg::FN_ALLOC, 2097151, 0, 1, bba_pkg::ST_BADSIZE, 0, 0);
		add_row(bba_pkg::FN_ALLOC, 1 << bba_pkg::POOL_ORDER, 0, 1, bba_pkg::ST_NOMEM, 0, 0);
		add_row(bba_pkg::FN_FREE, 0, 0, 1, bba_pkg::ST_BADFREE, 0, 0);
		add_row(bba_pkg::FN_FREE, 0, 24, 1, bba_pkg::ST_BADFREE, 0, 0);
		add_row(bba_pkg::FN_FREE, 0, 1048575, 1, bba_pkg::ST_BADFREE, 0, 0);
		add_row(bba_pkg::FN_ALLOC, 1, 0, 1, bba_pkg::ST_OK, 24, bba_pkg::LEAF_ORDER);
		add_row(bba_pkg::FN_ALLOC, 104, 0, 0, bba_pkg::ST_OK, 0, 0);
		add_row(bba_pkg::FN_ALLOC, 105, 0, 0, bba_pkg::ST_OK, 0, 0);
		add_row(bba_pkg::FN_FREE, 0, 25, 0, bba_pkg::ST_BADFREE, 0, 0);
		add_row(bba_pkg::FN_FREE, 0, 24, 0, bba_pkg::ST_OK, 0, 0);
		add_row(bba_pkg::FN_FREE, 0, 24, 0, bba_pkg::ST_BADFREE, 0, 0);
		add_row(bba_pkg::FN_ALLOC, (1 << 19) - 24, 0, 0, bba_pkg::ST_OK, 0, 0);
		add_row(bba_pkg::FN_ALLOC, (1 << 19) - 24, 0, 0, bba_pkg::ST_NOMEM, 0, 0);
		add_row(bba_pkg::FN_FREE, 0, 152, 0, bba_pkg::ST_OK, 0, 0);
		add_row(bba_pkg::FN_FREE, 0, 280, 0, bba_pkg::ST_OK, 0, 0);
		add_row(bba_pkg::FN_FREE, 0, (1 << 19) + 24, 0, bba_pkg::ST_OK, 0, 0);
		add_row(bba_pkg::FN_ALLOC, (1 << bba_pkg::POOL_ORDER) - 24, 0, 0, bba_pkg::ST_OK, 0, 0);
		add_row(bba_pkg::FN_FREE, 0, 24, 0, bba_pkg::ST_OK, 0, 0);
		add_row(bba_pkg::FN_FREE, 0, (1 << bba_pkg::POOL_ORDER) + 23, 0,
			bba_pkg::ST_BADFREE, 0, 0);
		foreach (dir_rows[i]) begin
			send_req(dir_rows[i].func, dir_rows[i].req, dir_rows[i].rel);
			pred = grant_q[$];
			if (dir_rows[i].typed && pred != dir_rows[i].want) begin
				$error("row %0d predictor expected %h actual %h",
					i, dir_rows[i].want, pred);
				row_errors++;
			end
		end

		// random phases across header settings and idling mixes
		done_items = 0;
		for (int ph = 0; ph < 5; ph++) begin
			case (ph)
				0: begin send_idle = 0;  recv_idle = 0;  end
				1: begin send_idle = 61; recv_idle = 0;  end
				2: begin send_idle = 0;  recv_idle = 61; end
				3: begin send_idle = 26; recv_idle = 26; end
				default: begin send_idle = $urandom_range(40); recv_idle = 0; end
			endcase
			// free everything first so header changes never strand live blocks
			while (live_q.size() != 0) send_req(bba_pkg::FN_FREE, '0, live_q[0]);
			case (ph)
				0: write_hdr(7'd0);
				1: write_hdr(7'd127);
				2: write_hdr(7'd64);
				3: write_hdr(bba_pkg::HDR_W'($urandom_range(64)));
				default: write_hdr(7'd1);
			endcase
			if (ph == 2) hold_go = 1'b1;  // receiver backs up, input must stall
			repeat (130) begin
				random_req();
				done_items++;
			end
		end
		// a header change with blocks still live
		write_hdr(7'd16);
		repeat (10) random_req();

		while (grant_q.size() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (errors + row_errors == 0)
			$display("buddy_block_allocator_unit_tb passed");
		else
			$display("buddy_block_allocator_unit_tb failed");
		$finish;
	end

endmodule
